// ===== src/ifri_pkg.sv =====
// ----------------------------------------------------------------------------
// ifri_pkg
// Types, register map and helpers shared by the IMU FIFO register interface.
// ----------------------------------------------------------------------------
package ifri_pkg;

  localparam int FIFO_SAMPLES     = 128;
  localparam int BYTES_PER_SAMPLE = 12;
  localparam int STORE_BYTES      = FIFO_SAMPLES * BYTES_PER_SAMPLE;
  localparam int ROW_W            = $clog2(FIFO_SAMPLES);
  localparam int CNT_W            = $clog2(STORE_BYTES + 1);
  localparam int CAP_W            = $clog2(FIFO_SAMPLES + 1);
  localparam int BYTE_IDX_W       = $clog2(BYTES_PER_SAMPLE);
  localparam int ROW_BITS         = 8 * BYTES_PER_SAMPLE;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_BYPASS    = 2'd0,
    MODE_STOP      = 2'd1,
    MODE_OVERWRITE = 2'd2,
    MODE_BYPASS_B  = 2'd3
  } fifo_mode_e;

  localparam logic [6:0] ADDR_ID        = 7'h00;
  localparam logic [6:0] ADDR_CTRL_LO   = 7'h02;
  localparam logic [6:0] ADDR_CTRL9     = 7'h0A;
  localparam logic [6:0] ADDR_WTM       = 7'h13;
  localparam logic [6:0] ADDR_FIFO_CTRL = 7'h14;
  localparam logic [6:0] ADDR_CNT_LO    = 7'h15;
  localparam logic [6:0] ADDR_STATUS    = 7'h16;
  localparam logic [6:0] ADDR_FIFO_DATA = 7'h17;
  localparam logic [6:0] ADDR_CMD_DONE  = 7'h2D;
  localparam logic [6:0] ADDR_READY     = 7'h2E;
  localparam logic [6:0] ADDR_TS_LO     = 7'h30;
  localparam logic [6:0] ADDR_TS_HI     = 7'h32;
  localparam logic [6:0] ADDR_OUT_LO    = 7'h35;
  localparam logic [6:0] ADDR_OUT_HI    = 7'h40;
  localparam logic [6:0] ADDR_RST_RES   = 7'h4D;
  localparam logic [6:0] ADDR_SOFT_RST  = 7'h60;

  localparam logic [7:0] ID_VALUE       = 8'h05;
  localparam logic [7:0] SOFT_RST_KEY   = 8'hB0;
  localparam logic [7:0] RST_RES_INIT   = 8'h80;
  localparam logic [7:0] CTRL1_INIT     = 8'h20;
  localparam logic [7:0] FIFO_CTRL_MASK = 8'h8F;
  localparam logic [7:0] CMD_ACK        = 8'h00;
  localparam logic [7:0] CMD_FIFO_RST   = 8'h04;
  localparam logic [7:0] CMD_FIFO_RD    = 8'h05;
  localparam logic [1:0] READY_ALL      = 2'h3;

  typedef struct packed {
    op_e                operation;
    logic [6:0]         reg_address;
    logic [7:0]         write_byte;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       watermark_irq;
  } out_item_t;

  typedef struct packed {
    logic                  mem_sel;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [7:0]            value;
    logic                  irq;
  } token_t;

  function automatic logic [CAP_W-1:0] cap_samples(input logic [1:0] size);
    logic [8:0] raw;
    raw = 9'd16 << size;
    if (raw > 9'(FIFO_SAMPLES)) raw = 9'(FIFO_SAMPLES);
    return CAP_W'(raw);
  endfunction

endpackage

// ===== src/ifri_front.sv =====
// ----------------------------------------------------------------------------
// ifri_front
// Decodes each transfer, updates registers and FIFO pointers, owns the store.
// ----------------------------------------------------------------------------
module ifri_front import ifri_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  in_item_t            item_i,
  output token_t              tok_o,
  output logic [ROW_BITS-1:0] rdata_o
);

  logic [ROW_BITS-1:0] mem [FIFO_SAMPLES];

  logic [ROW_W-1:0]      wp_q, wp_d, rp_row_q, rp_row_d;
  logic [BYTE_IDX_W-1:0] rp_byte_q, rp_byte_d;
  logic [CNT_W-1:0]      stored_q, stored_d;
  logic                  ovf_q, ovf_d, done_q, done_d;
  logic [7:0]            fctl_q, fctl_d, wtm_q, wtm_d, rres_q, rres_d;
  logic [8:0][7:0]       ctrl_q, ctrl_d;
  logic [1:0]            rdy_q, rdy_d;
  logic [23:0]           ts_q, ts_d;
  logic [11:0][7:0]      oreg_q, oreg_d;
  logic [ROW_BITS-1:0]   rdata_q;

  logic [ROW_BITS-1:0] row;
  logic                we, re;
  logic [7:0]          rd;
  logic [CAP_W-1:0]    cap_s;
  logic [CNT_W:0]      cap_b;
  logic [CNT_W:0]      stored_plus;
  logic [CNT_W:0]      words;
  logic [ROW_W:0]      adj;
  logic [ROW_W-1:0]    wp_inc;
  logic [6:0]          aoff;
  logic                full, wm_now, wm_next;
  fifo_mode_e          mode;

  assign row   = {item_i.gyro_z, item_i.gyro_y, item_i.gyro_x,
                  item_i.accel_z, item_i.accel_y, item_i.accel_x};
  assign mode  = fifo_mode_e'(fctl_q[1:0]);
  assign cap_s = cap_samples(fctl_q[3:2]);
  assign cap_b = (CNT_W+1)'(cap_s) * (CNT_W+1)'(BYTES_PER_SAMPLE);
  assign stored_plus = {1'b0, stored_q} + (CNT_W+1)'(BYTES_PER_SAMPLE);
  assign words = ({1'b0, stored_q} + (CNT_W+1)'(1)) >> 1;
  assign full  = {1'b0, stored_q} >= cap_b;
  assign wm_now = (wtm_q != 8'd0) &&
                  ({1'b0, stored_q} >= (CNT_W+1)'(wtm_q) * (CNT_W+1)'(BYTES_PER_SAMPLE));
  assign wm_next = (wtm_d != 8'd0) &&
                  ({1'b0, stored_d} >= (CNT_W+1)'(wtm_d) * (CNT_W+1)'(BYTES_PER_SAMPLE));
  assign wp_inc = (wp_q == ROW_W'(FIFO_SAMPLES - 1)) ? '0 : wp_q + ROW_W'(1);
  assign aoff  = item_i.reg_address - ADDR_OUT_LO;

  always_comb begin
    adj = {1'b0, wp_q} + (ROW_W+1)'(FIFO_SAMPLES + 1) - (ROW_W+1)'(cap_s);
    if (adj >= (ROW_W+1)'(FIFO_SAMPLES)) adj = adj - (ROW_W+1)'(FIFO_SAMPLES);
  end

  always_comb begin
    wp_d = wp_q; rp_row_d = rp_row_q; rp_byte_d = rp_byte_q; stored_d = stored_q;
    ovf_d = ovf_q; done_d = done_q; fctl_d = fctl_q; wtm_d = wtm_q; rres_d = rres_q;
    ctrl_d = ctrl_q; rdy_d = rdy_q; ts_d = ts_q; oreg_d = oreg_q;
    we = 1'b0; re = 1'b0; rd = 8'd0;
    if (acc_i) begin
      unique case (item_i.operation)
        OP_SAMPLE: begin
          if (mode == MODE_BYPASS || mode == MODE_BYPASS_B) begin
            oreg_d = row;
            rdy_d  = READY_ALL;
            ts_d   = ts_q + 24'd1;
          end else if (fctl_q[7]) begin
            ovf_d = 1'b1;
          end else if (stored_plus > cap_b) begin
            ovf_d = 1'b1;
            if (mode == MODE_OVERWRITE) begin
              rp_row_d  = adj[ROW_W-1:0];
              rp_byte_d = '0;
              stored_d  = cap_b[CNT_W-1:0];
              we   = 1'b1;
              wp_d = wp_inc;
            end
          end else begin
            we       = 1'b1;
            wp_d     = wp_inc;
            stored_d = stored_plus[CNT_W-1:0];
          end
        end
        OP_READ: begin
          priority if (item_i.reg_address == ADDR_ID) begin
            rd = ID_VALUE;
          end else if (item_i.reg_address >= ADDR_CTRL_LO &&
                       item_i.reg_address <= ADDR_CTRL9) begin
            rd = ctrl_q[4'(item_i.reg_address - ADDR_CTRL_LO)];
          end else if (item_i.reg_address >= ADDR_OUT_LO &&
                       item_i.reg_address <= ADDR_OUT_HI) begin
            rd = oreg_q[aoff[3:0]];
          end else if (item_i.reg_address >= ADDR_TS_LO &&
                       item_i.reg_address <= ADDR_TS_HI) begin
            rd = ts_q[8*(item_i.reg_address[1:0])+:8];
          end else if (item_i.reg_address == ADDR_WTM) begin
            rd = wtm_q;
          end else if (item_i.reg_address == ADDR_FIFO_CTRL) begin
            rd = fctl_q;
          end else if (item_i.reg_address == ADDR_CNT_LO) begin
            rd = words[7:0];
          end else if (item_i.reg_address == ADDR_STATUS) begin
            rd = {full, wm_now, ovf_q, stored_q != '0, 2'b00, words[9:8]};
          end else if (item_i.reg_address == ADDR_FIFO_DATA) begin
            if (stored_q != '0) begin
              re       = 1'b1;
              stored_d = stored_q - CNT_W'(1);
              if (rp_byte_q == BYTE_IDX_W'(BYTES_PER_SAMPLE - 1)) begin
                rp_byte_d = '0;
                rp_row_d  = (rp_row_q == ROW_W'(FIFO_SAMPLES - 1)) ? '0
                                                                   : rp_row_q + ROW_W'(1);
              end else begin
                rp_byte_d = rp_byte_q + BYTE_IDX_W'(1);
              end
            end
          end else if (item_i.reg_address == ADDR_CMD_DONE) begin
            rd = {done_q, 7'd0};
          end else if (item_i.reg_address == ADDR_READY) begin
            rd    = {6'd0, rdy_q};
            rdy_d = 2'd0;
          end else if (item_i.reg_address == ADDR_RST_RES) begin
            rd = rres_q;
          end else begin
            rd = 8'd0;
          end
        end
        OP_WRITE: begin
          priority if (item_i.reg_address >= ADDR_CTRL_LO &&
                       item_i.reg_address <= ADDR_CTRL9) begin
            ctrl_d[4'(item_i.reg_address - ADDR_CTRL_LO)] = item_i.write_byte;
            if (item_i.reg_address == ADDR_CTRL9) begin
              priority if (item_i.write_byte == CMD_FIFO_RST) begin
                wp_d = '0; rp_row_d = '0; rp_byte_d = '0; stored_d = '0; ovf_d = 1'b0;
                done_d = 1'b1;
              end else if (item_i.write_byte == CMD_FIFO_RD) begin
                fctl_d[7] = 1'b1;
                done_d    = 1'b1;
              end else if (item_i.write_byte == CMD_ACK) begin
                done_d = 1'b0;
              end else begin
                done_d = done_q;
              end
            end
          end else if (item_i.reg_address == ADDR_WTM) begin
            wtm_d = item_i.write_byte;
          end else if (item_i.reg_address == ADDR_FIFO_CTRL) begin
            fctl_d = item_i.write_byte & FIFO_CTRL_MASK;
          end else if (item_i.reg_address == ADDR_RST_RES) begin
            rres_d = item_i.write_byte;
          end else if (item_i.reg_address == ADDR_SOFT_RST &&
                       item_i.write_byte == SOFT_RST_KEY) begin
            wp_d = '0; rp_row_d = '0; rp_byte_d = '0; stored_d = '0; ovf_d = 1'b0;
            done_d = 1'b0; fctl_d = '0; wtm_d = '0; rres_d = RST_RES_INIT;
            ctrl_d = '0; ctrl_d[0] = CTRL1_INIT; rdy_d = '0; ts_d = '0; oreg_d = '0;
          end else begin
            wtm_d = wtm_q;
          end
        end
        OP_NONE: rd = 8'd0;
        default: rd = 8'd0;
      endcase
    end
  end

  always_comb begin
    tok_o.mem_sel  = re;
    tok_o.byte_idx = rp_byte_q;
    tok_o.value    = rd;
    tok_o.irq      = wm_next;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wp_q] <= row;
    if (re) rdata_q <= mem[rp_row_q];
  end

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_row_q <= '0; rp_byte_q <= '0; stored_q <= '0;
      ovf_q <= 1'b0; done_q <= 1'b0; fctl_q <= '0; wtm_q <= '0;
      rres_q <= RST_RES_INIT; ctrl_q <= {{8{8'h00}}, CTRL1_INIT};
      rdy_q <= '0; ts_q <= '0; oreg_q <= '0;
    end else begin
      wp_q <= wp_d; rp_row_q <= rp_row_d; rp_byte_q <= rp_byte_d; stored_q <= stored_d;
      ovf_q <= ovf_d; done_q <= done_d; fctl_q <= fctl_d; wtm_q <= wtm_d;
      rres_q <= rres_d; ctrl_q <= ctrl_d; rdy_q <= rdy_d; ts_q <= ts_d; oreg_q <= oreg_d;
    end
  end

  a_stored_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CNT_W'(STORE_BYTES)) else $error("stored byte count too large");
  a_byte_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_byte_q < BYTE_IDX_W'(BYTES_PER_SAMPLE)) else $error("read byte index out of row");
  a_soft_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && item_i.operation == OP_WRITE && item_i.reg_address == ADDR_SOFT_RST &&
    item_i.write_byte == SOFT_RST_KEY |=> stored_q == '0 && fctl_q == '0)
    else $error("soft reset did not clear FIFO");

endmodule

// ===== src/ifri_back.sv =====
// ----------------------------------------------------------------------------
// ifri_back
// Result queue: one pending entry plus output register, selects FIFO byte.
// ----------------------------------------------------------------------------
module ifri_back import ifri_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  token_t              tok_i,
  input  logic [ROW_BITS-1:0] rdata_i,
  output logic                push_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  logic      a_valid_q, a_valid_d, o_valid_q, o_valid_d;
  token_t    a_tok_q;
  out_item_t o_q;
  logic      o_free, a_move;
  logic [7:0] byte_val;
  logic [BYTES_PER_SAMPLE-1:0][7:0] row_bytes;

  assign row_bytes    = rdata_i;
  assign o_free       = !o_valid_q || !out_stall_i;
  assign a_move       = a_valid_q && o_free;
  assign push_ready_o = !a_valid_q || a_move;
  assign byte_val     = a_tok_q.mem_sel ? row_bytes[a_tok_q.byte_idx] : a_tok_q.value;

  always_comb begin
    a_valid_d = push_i ? 1'b1 : (a_move ? 1'b0 : a_valid_q);
    o_valid_d = a_move ? 1'b1 : (o_free ? 1'b0 : o_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) a_tok_q <= tok_i;
    if (a_move) begin
      o_q.read_byte     <= byte_val;
      o_q.watermark_irq <= a_tok_q.irq;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

endmodule

// ===== src/imu_fifo_register_interface_unit.sv =====
// ----------------------------------------------------------------------------
// imu_fifo_register_interface_unit
// Register block of a six-axis sensor with sample FIFO and output registers.
// ----------------------------------------------------------------------------
// Path: an accepted transfer is registered in the pending entry, then in the output register.
// Throughput: one transfer per cycle unless the output stalls; the FIFO
// store has one write and one registered read port, one row per sample.
// Reset: asynchronous; clears control and valid state, not data or store.
module imu_fifo_register_interface_unit import ifri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic                push_ready, acc;
  token_t              tok;
  logic [ROW_BITS-1:0] rdata;

  assign acc        = in_valid_i && push_ready;
  assign in_stall_o = !push_ready;

  ifri_front u_front (
    .clk_i, .rst_ni,
    .acc_i   (acc),
    .item_i  (in_data_i),
    .tok_o   (tok),
    .rdata_o (rdata)
  );

  ifri_back u_back (
    .clk_i, .rst_ni,
    .push_i       (acc),
    .tok_i        (tok),
    .rdata_i      (rdata),
    .push_ready_o (push_ready),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

// ===== tb/ifri_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ifri_checker
// Watches both transfer channels of the IMU FIFO register block, predicts
// each result from its own model of the register map and sample FIFO, and
// compares read byte and watermark flag in order. Reports a failure count.
// ----------------------------------------------------------------------------
module ifri_checker import ifri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [7:0]  fifo_mem [STORE_BYTES];
  int          rd_ptr, wr_ptr, fill_bytes;
  logic        ovf;
  logic [7:0]  fifo_cfg, wtm;
  logic [7:0]  ctrl [9];
  logic        cmd_done;
  logic [1:0]  ready;
  logic [23:0] tstamp;
  logic [7:0]  out_regs [12];
  logic [7:0]  rst_res;
  out_item_t   expected_q [$];

  function automatic int cap_bytes();
    int c;
    c = 16 << fifo_cfg[3:2];
    if (c > FIFO_SAMPLES) c = FIFO_SAMPLES;
    return c * BYTES_PER_SAMPLE;
  endfunction

  function automatic logic wtm_hit();
    return wtm != 0 && (fill_bytes / BYTES_PER_SAMPLE) >= wtm;
  endfunction

  task automatic model_reset();
    rd_ptr = 0; wr_ptr = 0; fill_bytes = 0; ovf = 0;
    fifo_cfg = 0; wtm = 0;
    foreach (ctrl[i]) ctrl[i] = 0;
    ctrl[0] = CTRL1_INIT;
    cmd_done = 0; ready = 0; tstamp = 0;
    foreach (out_regs[i]) out_regs[i] = 0;
    rst_res = RST_RES_INIT;
  endtask

  task automatic take_sample(input in_item_t it);
    logic [7:0] b [12];
    logic [15:0] ax [6];
    int drop;
    ax[0] = it.accel_x; ax[1] = it.accel_y; ax[2] = it.accel_z;
    ax[3] = it.gyro_x;  ax[4] = it.gyro_y;  ax[5] = it.gyro_z;
    for (int i = 0; i < 6; i++) begin
      b[2*i] = ax[i][7:0];
      b[2*i+1] = ax[i][15:8];
    end
    if (fifo_cfg[1:0] == MODE_BYPASS || fifo_cfg[1:0] == MODE_BYPASS_B) begin
      foreach (b[i]) out_regs[i] = b[i];
      ready = READY_ALL;
      tstamp = tstamp + 24'd1;
      return;
    end
    if (fifo_cfg[7]) begin
      ovf = 1;
      return;
    end
    if (fill_bytes + BYTES_PER_SAMPLE > cap_bytes()) begin
      ovf = 1;
      if (fifo_cfg[1:0] == MODE_STOP) return;
      drop = fill_bytes + BYTES_PER_SAMPLE - cap_bytes();
      if (drop > fill_bytes) drop = fill_bytes;
      rd_ptr = (rd_ptr + drop) % STORE_BYTES;
      fill_bytes -= drop;
    end
    for (int i = 0; i < BYTES_PER_SAMPLE; i++) begin
      fifo_mem[wr_ptr] = b[i];
      wr_ptr = (wr_ptr + 1) % STORE_BYTES;
    end
    fill_bytes += BYTES_PER_SAMPLE;
  endtask

  function automatic logic [7:0] reg_read(input logic [6:0] a);
    int words;
    logic [7:0] v;
    words = (fill_bytes + 1) >> 1;
    if (a == ADDR_ID) return ID_VALUE;
    if (a >= ADDR_CTRL_LO && a <= ADDR_CTRL9) return ctrl[a - ADDR_CTRL_LO];
    if (a >= ADDR_OUT_LO && a <= ADDR_OUT_HI) return out_regs[a - ADDR_OUT_LO];
    if (a >= ADDR_TS_LO && a <= ADDR_TS_HI)
      return 8'(tstamp >> (8 * (a - ADDR_TS_LO)));
    case (a)
      ADDR_WTM:       return wtm;
      ADDR_FIFO_CTRL: return fifo_cfg;
      ADDR_CNT_LO:    return words[7:0];
      ADDR_STATUS: begin
        v = {6'd0, words[9:8]};
        if (fill_bytes >= cap_bytes()) v[7] = 1;
        if (wtm_hit()) v[6] = 1;
        if (ovf) v[5] = 1;
        if (fill_bytes != 0) v[4] = 1;
        return v;
      end
      ADDR_FIFO_DATA: begin
        if (fill_bytes == 0) return 0;
        v = fifo_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % STORE_BYTES;
        fill_bytes--;
        return v;
      end
      ADDR_CMD_DONE: return cmd_done ? 8'h80 : 8'h00;
      ADDR_READY: begin
        v = {6'd0, ready};
        ready = 0;
        return v;
      end
      ADDR_RST_RES: return rst_res;
      default: return 0;
    endcase
  endfunction

  task automatic reg_write(input logic [6:0] a, input logic [7:0] v);
    if (a >= ADDR_CTRL_LO && a <= ADDR_CTRL9) begin
      ctrl[a - ADDR_CTRL_LO] = v;
      if (a == ADDR_CTRL9) begin
        if (v == CMD_FIFO_RST) begin
          rd_ptr = 0; wr_ptr = 0; fill_bytes = 0; ovf = 0;
          cmd_done = 1;
        end else if (v == CMD_FIFO_RD) begin
          fifo_cfg[7] = 1;
          cmd_done = 1;
        end else if (v == CMD_ACK) cmd_done = 0;
      end
      return;
    end
    case (a)
      ADDR_WTM:       wtm = v;
      ADDR_FIFO_CTRL: fifo_cfg = v & FIFO_CTRL_MASK;
      ADDR_RST_RES:   rst_res = v;
      ADDR_SOFT_RST:  if (v == SOFT_RST_KEY) model_reset();
      default: ;
    endcase
  endtask

  task automatic predict(input in_item_t it);
    out_item_t r;
    r.read_byte = 0;
    case (it.operation)
      OP_SAMPLE: take_sample(it);
      OP_READ:   r.read_byte = reg_read(it.reg_address);
      OP_WRITE:  reg_write(it.reg_address, it.write_byte);
      default: ;
    endcase
    r.watermark_irq = wtm_hit();
    expected_q.push_back(r);
  endtask

  initial begin
    model_reset();
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.read_byte !== out_data_i.read_byte) begin
            $display("%0t: read_byte expected %h actual %h",
                     $time, e.read_byte, out_data_i.read_byte);
            fail_count_o <= fail_count_o + 1;
          end else if (e.watermark_irq !== out_data_i.watermark_irq) begin
            $display("%0t: watermark_irq expected %b actual %b",
                     $time, e.watermark_irq, out_data_i.watermark_irq);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the IMU FIFO register block: directed register and FIFO cases,
// then random FIFO fill/drain sequences with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import ifri_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending;
  bit        quiet;

  imu_fifo_register_interface_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  ifri_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 23);
  end

  function automatic in_item_t rnd_sample();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.operation = OP_SAMPLE;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic access(input op_e op, input logic [6:0] a, input logic [7:0] d);
    in_item_t it;
    it = rnd_sample();
    it.operation = op;
    it.reg_address = a;
    it.write_byte = d;
    send(it);
  endtask

  task automatic sample_extreme(input logic signed [15:0] v);
    in_item_t it;
    it = rnd_sample();
    {it.accel_x, it.accel_y, it.accel_z} = {v, v, v};
    {it.gyro_x, it.gyro_y, it.gyro_z} = {v, v, v};
    send(it);
  endtask

  initial begin
    int n;
    logic [6:0] a;
    rst_n = 0; in_valid = 0; out_stall = 0; quiet = 0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    access(OP_READ, ADDR_ID, 0);
    sample_extreme(16'sh7FFF);
    sample_extreme(-16'sh8000);
    access(OP_READ, ADDR_READY, 0);
    access(OP_READ, ADDR_READY, 0);
    access(OP_READ, ADDR_OUT_LO, 0);
    access(OP_READ, ADDR_TS_LO, 0);
    access(OP_NONE, 7'h7F, 8'hFF);
    access(OP_WRITE, ADDR_WTM, 8'd1);
    access(OP_WRITE, ADDR_FIFO_CTRL, 8'hFD);
    repeat (3) sample_extreme(16'sh1234);
    access(OP_READ, ADDR_STATUS, 0);
    access(OP_READ, ADDR_FIFO_DATA, 0);
    access(OP_WRITE, ADDR_CTRL9, CMD_FIFO_RD);
    sample_extreme(16'sh0001);
    access(OP_READ, ADDR_CMD_DONE, 0);
    access(OP_WRITE, ADDR_CTRL9, CMD_ACK);
    access(OP_WRITE, ADDR_CTRL9, CMD_FIFO_RST);
    access(OP_READ, ADDR_FIFO_DATA, 0);
    access(OP_WRITE, ADDR_SOFT_RST, 8'h11);
    access(OP_WRITE, ADDR_RST_RES, 8'h00);
    access(OP_WRITE, ADDR_SOFT_RST, SOFT_RST_KEY);
    access(OP_READ, ADDR_RST_RES, 0);
    access(OP_READ, 7'h7F, 0);
    // random: configure, fill, drain
    n = 0;
    while (n < 1650) begin
      quiet = (n > 700 && n < 900);
      access(OP_WRITE, ADDR_FIFO_CTRL,
             {1'b0, 3'b0, 2'($urandom_range(3)), 2'($urandom_range(3))} |
             ($urandom_range(9) == 0 ? 8'h80 : 8'h00));
      access(OP_WRITE, ADDR_WTM, $urandom_range(3) == 0 ? 8'($urandom) :
             8'($urandom_range(40)));
      n += 2;
      repeat ($urandom_range(1, 40)) begin
        send(rnd_sample());
        n++;
      end
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(9))
          0: a = 7'($urandom);
          1: a = ADDR_STATUS;
          2: a = ADDR_CNT_LO;
          3: a = ADDR_READY;
          4: a = 7'($urandom_range(ADDR_OUT_LO, ADDR_OUT_HI));
          default: a = ADDR_FIFO_DATA;
        endcase
        access(OP_READ, a, 0);
        n++;
      end
      case ($urandom_range(7))
        0: access(OP_WRITE, ADDR_CTRL9, CMD_FIFO_RST);
        1: access(OP_WRITE, ADDR_CTRL9, CMD_FIFO_RD);
        2: access(OP_WRITE, ADDR_CTRL9, CMD_ACK);
        3: access(OP_WRITE, 7'($urandom), 8'($urandom));
        4: access(OP_WRITE, 7'($urandom_range(ADDR_CTRL_LO, ADDR_CTRL9)),
                  8'($urandom));
        5: access(OP_WRITE, ADDR_RST_RES, 8'($urandom));
        6: access(op_e'(2'($urandom)), 7'($urandom), 8'($urandom));
        default: access(OP_READ, ADDR_CMD_DONE, 0);
      endcase
      n++;
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
